// ===== hw/rtl/lpsc_pkg.sv =====
`default_nettype none
package lpsc_pkg;

	localparam logic [2:0] LEN_BYTES_RESET = 3'd4;
	localparam logic [2:0] LEN_BYTES_MAX   = 3'd4;
	localparam logic [2:0] LEN_BYTES_MIN   = 3'd1;

	localparam logic [7:0] SC_ZERO = 8'h00;
	localparam logic [7:0] SC_ONE  = 8'h01;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_TRUNC   = 2'd1;
	localparam logic [1:0] ST_OVERRUN = 2'd2;
	localparam logic [1:0] ST_NEG     = 2'd3;

	typedef enum logic [2:0] {
		PH_LEN     = 3'b001,
		PH_PAYLOAD = 3'b010,
		PH_DROP    = 3'b100
	} phase_t;

	// What one input beat asks the emitter to send.
	typedef struct packed {
		logic       en;
		logic       sc;
		logic       sc_first;
		logic [7:0] data;
		logic       data_valid;
		logic       last;
		logic [1:0] status;
	} res_t;

endpackage
`default_nettype wire

// ===== hw/rtl/length_prefix_to_start_code_core.sv =====
`default_nettype none
// Channel  Direction  Handshake             Payload
// in       sink       in_valid / in_stall   in_byte[7:0], in_last
// out      source     out_valid / out_stall out_byte[7:0], byte_valid, out_last, out_status[1:0]
// cfg      sink       cfg_wr_en             cfg_wr_data[2:0] (length field bytes)
//
// A payload beat passes through the input and then the output register, one byte per cycle
// while the output does not stall. A completed length field yields a start code of three or
// four beats at the same rate; the input stalls while they drain from the output register.
// Reset returns the packet state to the start of a packet and the width to four bytes.
// A stall on the output holds the output register and backs up into the input register.
module length_prefix_to_start_code_core (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] in_byte,
	input  wire logic       in_last,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      out_byte,
	output logic            byte_valid,
	output logic            out_last,
	output logic [1:0]      out_status,
	input  wire logic       cfg_wr_en,
	input  wire logic [2:0] cfg_wr_data
);

	logic           valid_s1;
	logic [7:0]     byte_s1;
	logic           last_s1;
	logic [2:0]     len_bytes_q;
	logic           res_take;
	lpsc_pkg::res_t res;

	assign in_stall = valid_s1 && !res_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			len_bytes_q <= lpsc_pkg::LEN_BYTES_RESET;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (cfg_wr_en) begin
				len_bytes_q <= cfg_wr_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

	lpsc_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.beat_en   (valid_s1 && res_take),
		.beat_byte (byte_s1),
		.beat_last (last_s1),
		.len_bytes (len_bytes_q),
		.res       (res)
	);

	lpsc_emitter u_emitter (
		.clk        (clk),
		.arst_n     (arst_n),
		.res_valid  (valid_s1),
		.res        (res),
		.res_take   (res_take),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.byte_valid (byte_valid),
		.out_last   (out_last),
		.out_status (out_status)
	);

endmodule
`default_nettype wire

// ===== hw/rtl/lpsc_parser.sv =====
`default_nettype none
module lpsc_parser (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             beat_en,
	input  wire logic [7:0]       beat_byte,
	input  wire logic             beat_last,
	input  wire logic [2:0]       len_bytes,
	output lpsc_pkg::res_t        res
);

	lpsc_pkg::phase_t phase_q, phase_nx;
	logic [2:0]  seen_q, seen_nx;
	logic [31:0] rem_q, rem_nx;
	logic        first_q, first_nx;
	logic [1:0]  err_q, err_nx;

	logic [2:0]  width;
	logic [2:0]  seen_inc;
	logic [31:0] len_val;
	logic [31:0] rem_dec;

	always_comb begin
		if (len_bytes == 3'd0) begin
			width = lpsc_pkg::LEN_BYTES_MIN;
		end else if (len_bytes > lpsc_pkg::LEN_BYTES_MAX) begin
			width = lpsc_pkg::LEN_BYTES_MAX;
		end else begin
			width = len_bytes;
		end
	end

	assign seen_inc = seen_q + 3'd1;
	assign len_val  = {rem_q[23:0], beat_byte};
	assign rem_dec  = rem_q - 32'd1;

	always_comb begin
		phase_nx = phase_q;
		seen_nx  = seen_q;
		rem_nx   = rem_q;
		first_nx = first_q;
		err_nx   = err_q;
		res      = '0;

		if (phase_q == lpsc_pkg::PH_DROP) begin
			if (beat_last) begin
				res.en     = 1'b1;
				res.last   = 1'b1;
				res.status = err_q;
			end
		end else if (phase_q == lpsc_pkg::PH_PAYLOAD && rem_q != 32'd0) begin
			res.en         = 1'b1;
			res.data       = beat_byte;
			res.data_valid = 1'b1;
			res.last       = beat_last;
			rem_nx         = rem_dec;
			if (rem_dec == 32'd0) begin
				res.status = lpsc_pkg::ST_OK;
				phase_nx   = lpsc_pkg::PH_LEN;
				seen_nx    = 3'd0;
			end else if (beat_last) begin
				res.status = lpsc_pkg::ST_OVERRUN;
			end
		end else begin
			phase_nx = lpsc_pkg::PH_LEN;
			if (seen_inc < width) begin
				rem_nx  = len_val;
				seen_nx = seen_inc;
				if (beat_last) begin
					res.en     = 1'b1;
					res.last   = 1'b1;
					res.status = lpsc_pkg::ST_TRUNC;
				end
			end else if (width == lpsc_pkg::LEN_BYTES_MAX && len_val[31]) begin
				if (beat_last) begin
					res.en     = 1'b1;
					res.last   = 1'b1;
					res.status = lpsc_pkg::ST_NEG;
				end else begin
					err_nx   = lpsc_pkg::ST_NEG;
					phase_nx = lpsc_pkg::PH_DROP;
					seen_nx  = 3'd0;
					rem_nx   = 32'd0;
				end
			end else if (beat_last && len_val != 32'd0) begin
				res.en     = 1'b1;
				res.last   = 1'b1;
				res.status = lpsc_pkg::ST_OVERRUN;
			end else begin
				res.en       = 1'b1;
				res.sc       = 1'b1;
				res.sc_first = first_q;
				res.last     = beat_last;
				first_nx     = 1'b0;
				seen_nx      = 3'd0;
				rem_nx       = len_val;
				phase_nx     = (len_val != 32'd0) ? lpsc_pkg::PH_PAYLOAD : lpsc_pkg::PH_LEN;
			end
		end

		// Every packet ends with its state back at the reset values.
		if (beat_last) begin
			phase_nx = lpsc_pkg::PH_LEN;
			seen_nx  = 3'd0;
			rem_nx   = 32'd0;
			first_nx = 1'b1;
			err_nx   = lpsc_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= lpsc_pkg::PH_LEN;
			seen_q  <= 3'd0;
			rem_q   <= 32'd0;
			first_q <= 1'b1;
			err_q   <= lpsc_pkg::ST_OK;
		end else if (beat_en) begin
			phase_q <= phase_nx;
			seen_q  <= seen_nx;
			rem_q   <= rem_nx;
			first_q <= first_nx;
			err_q   <= err_nx;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/lpsc_emitter.sv =====
`default_nettype none
module lpsc_emitter (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           res_valid,
	input  wire lpsc_pkg::res_t res,
	output logic                res_take,
	output logic                out_valid,
	input  wire logic           out_stall,
	output logic [7:0]          out_byte,
	output logic                byte_valid,
	output logic                out_last,
	output logic [1:0]          out_status
);

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       byte_valid_q;
	logic       out_last_q;
	logic [1:0] out_status_q;
	logic [1:0] pend_q;
	logic       pend_last_q;
	logic       advance;

	assign advance  = !out_valid_q || !out_stall;
	assign res_take = advance && (pend_q == 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_q      <= 2'd0;
			pend_last_q <= 1'b0;
		end else if (advance) begin
			if (pend_q != 2'd0) begin
				out_valid_q <= 1'b1;
				pend_q      <= pend_q - 2'd1;
			end else if (res_valid && res.en) begin
				out_valid_q <= 1'b1;
				if (res.sc) begin
					pend_q      <= res.sc_first ? 2'd3 : 2'd2;
					pend_last_q <= res.last;
				end
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (pend_q != 2'd0) begin
				out_byte_q   <= (pend_q == 2'd1) ? lpsc_pkg::SC_ONE : lpsc_pkg::SC_ZERO;
				byte_valid_q <= 1'b1;
				out_last_q   <= (pend_q == 2'd1) && pend_last_q;
				out_status_q <= lpsc_pkg::ST_OK;
			end else if (res.sc) begin
				out_byte_q   <= lpsc_pkg::SC_ZERO;
				byte_valid_q <= 1'b1;
				out_last_q   <= 1'b0;
				out_status_q <= lpsc_pkg::ST_OK;
			end else begin
				out_byte_q   <= res.data;
				byte_valid_q <= res.data_valid;
				out_last_q   <= res.last;
				out_status_q <= res.status;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign byte_valid = byte_valid_q;
	assign out_last   = out_last_q;
	assign out_status = out_status_q;

endmodule
`default_nettype wire
